### hdl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, constants and types of the uv-sphere vertex and quad generator.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

  // field widths
  localparam int COUNT_W = 10;
  localparam int IDX_W   = 10;
  localparam int TRI_W   = 20;
  localparam int POS_W   = 16;

  // count limits and reset values
  localparam int MAX_DIVISIONS   = 1024;
  localparam int COORD_FRAC_BITS = 14;
  localparam int SECTOR_RESET    = 36;
  localparam int STACK_RESET     = 18;

  // phase and fixed-point format
  localparam int PHASE_W = 32;
  localparam int FRAC_Q  = 30;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  // long division of the phase: two quotient bits per stage
  localparam int DIVIDEND_W = 42;
  localparam int DIV_STAGES = DIVIDEND_W / 2;

  // sine / cosine series
  localparam int N_TERMS   = 8;
  localparam int SC_STAGES = 2 + 3 * N_TERMS + 1;

  // coordinate products and rounding
  localparam int CO_STAGES = 2;

  localparam int PIPE_DEPTH = DIV_STAGES + SC_STAGES + CO_STAGES;

  typedef logic [COUNT_W-1:0] count_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_SECTOR_COUNT = 1'b0,
    REG_STACK_COUNT  = 1'b1
  } cfg_reg_t;

  // index and flag data that rides alongside the math pipeline
  typedef struct packed {
    logic [TRI_W-1:0] a;
    logic [TRI_W-1:0] b;
    logic [TRI_W-1:0] a1;
    logic [TRI_W-1:0] b1;
    logic             vertex_ok;
    logic             quad_ok;
  } side_t;

endpackage

`default_nettype wire

### hdl/uvs_in_if.sv
// ----------------------------------------------------------------------------
// uvs_in_if
// Grid position channel: valid/ready handshake with stack and sector index.
// ----------------------------------------------------------------------------
`default_nettype none

interface uvs_in_if;
  import uvs_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] stack_index;
  logic [IDX_W-1:0] sector_index;

  modport source (output valid, stack_index, sector_index, input ready);
  modport sink   (input valid, stack_index, sector_index, output ready);
endinterface

`default_nettype wire

### hdl/uvs_out_if.sv
// ----------------------------------------------------------------------------
// uvs_out_if
// Vertex channel: valid/ready handshake with position, flags and quad indices.
// ----------------------------------------------------------------------------
`default_nettype none

interface uvs_out_if;
  import uvs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic                    vertex_ok;
  logic                    quad_ok;
  logic [TRI_W-1:0]        tri0_a;
  logic [TRI_W-1:0]        tri0_b;
  logic [TRI_W-1:0]        tri0_c;
  logic [TRI_W-1:0]        tri1_a;
  logic [TRI_W-1:0]        tri1_b;
  logic [TRI_W-1:0]        tri1_c;

  modport source (output valid, pos_x, pos_y, pos_z, vertex_ok, quad_ok,
                  tri0_a, tri0_b, tri0_c, tri1_a, tri1_b, tri1_c, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vertex_ok, quad_ok,
                  tri0_a, tri0_b, tri0_c, tri1_a, tri1_b, tri1_c, output ready);
endinterface

`default_nettype wire

### hdl/uvs_phase_div.sv
// ----------------------------------------------------------------------------
// uvs_phase_div
// Pipelined restoring divider giving the sector and stack phase quotients.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_phase_div import uvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [IDX_W-1:0]   stack_index,
  input  logic [IDX_W-1:0]   sector_index,
  input  count_t             sectors,
  input  count_t             stacks,
  output logic               out_valid,
  output logic [PHASE_W-1:0] sec_quo,
  output logic [PHASE_W-1:0] stk_quo
);

  // one restoring step: returns quotient bit and new remainder
  function automatic logic [COUNT_W:0] div_step(input count_t r, input logic b,
                                                input count_t d);
    logic [COUNT_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      return {1'b1, COUNT_W'(t - {1'b0, d})};
    end
    return {1'b0, t[COUNT_W-1:0]};
  endfunction

  logic                  v    [DIV_STAGES];
  logic [DIVIDEND_W-1:0] se_n [DIV_STAGES];
  logic [DIVIDEND_W-1:0] st_n [DIV_STAGES];
  count_t                se_r [DIV_STAGES];
  count_t                st_r [DIV_STAGES];
  logic [PHASE_W-1:0]    se_q [DIV_STAGES];
  logic [PHASE_W-1:0]    st_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic                  v_cur;
    logic [DIVIDEND_W-1:0] se_n_cur, st_n_cur;
    count_t                se_r_cur, st_r_cur;
    logic [PHASE_W-1:0]    se_q_cur, st_q_cur;
    logic [COUNT_W:0]      se_t1, se_t2, st_t1, st_t2;

    // dividends: j * 2^32 + sectors/2 and i * 2^31 + stacks/2
    if (k == 0) begin : g_first
      assign v_cur    = in_valid;
      assign se_n_cur = {sector_index, 32'(sectors >> 1)};
      assign st_n_cur = {1'b0, stack_index, 31'(stacks >> 1)};
      assign se_r_cur = '0;
      assign st_r_cur = '0;
      assign se_q_cur = '0;
      assign st_q_cur = '0;
    end else begin : g_next
      assign v_cur    = v[k-1];
      assign se_n_cur = se_n[k-1];
      assign st_n_cur = st_n[k-1];
      assign se_r_cur = se_r[k-1];
      assign st_r_cur = st_r[k-1];
      assign se_q_cur = se_q[k-1];
      assign st_q_cur = st_q[k-1];
    end

    // two quotient bits per stage
    always_comb begin
      se_t1 = div_step(se_r_cur, se_n_cur[DIVIDEND_W-1], sectors);
      se_t2 = div_step(se_t1[COUNT_W-1:0], se_n_cur[DIVIDEND_W-2], sectors);
      st_t1 = div_step(st_r_cur, st_n_cur[DIVIDEND_W-1], stacks);
      st_t2 = div_step(st_t1[COUNT_W-1:0], st_n_cur[DIVIDEND_W-2], stacks);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        se_n[k] <= se_n_cur << 2;
        st_n[k] <= st_n_cur << 2;
        se_r[k] <= se_t2[COUNT_W-1:0];
        st_r[k] <= st_t2[COUNT_W-1:0];
        se_q[k] <= {se_q_cur[PHASE_W-3:0], se_t1[COUNT_W], se_t2[COUNT_W]};
        st_q[k] <= {st_q_cur[PHASE_W-3:0], st_t1[COUNT_W], st_t2[COUNT_W]};
      end
    end
  end

  assign out_valid = v[DIV_STAGES-1];
  assign sec_quo   = se_q[DIV_STAGES-1];
  assign stk_quo   = st_q[DIV_STAGES-1];

endmodule

`default_nettype wire

### hdl/uvs_sincos.sv
// ----------------------------------------------------------------------------
// uvs_sincos
// Pipelined sine and cosine of a 32-bit phase, Q30 result, series evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_sincos import uvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [PHASE_W-1:0] phase,
  output logic               out_valid,
  output logic signed [31:0] sn,
  output logic signed [31:0] cs
);

  localparam logic [31:0]        ONE_Q  = 32'd1 << FRAC_Q;
  localparam logic signed [33:0] ONE_A  = 34'sd1 <<< FRAC_Q;

  // quadrant split and angle in radians
  logic        va;
  logic [1:0]  qa;
  logic [30:0] xa;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qa <= phase[PHASE_W-1:PHASE_W-2];
      xa <= 31'((64'(phase[PHASE_W-3:0]) * 64'(HALF_PI_Q30)) >> FRAC_Q);
    end
  end

  // series chain: element 0 holds the first terms and x squared
  logic                v   [N_TERMS+1];
  logic [1:0]          q   [N_TERMS+1];
  logic [31:0]         x2  [N_TERMS+1];
  logic [31:0]         ts  [N_TERMS+1];
  logic [31:0]         tc  [N_TERMS+1];
  logic signed [33:0]  s   [N_TERMS+1];
  logic signed [33:0]  c   [N_TERMS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q[0]  <= qa;
      x2[0] <= 32'((64'(xa) * 64'(xa)) >> FRAC_Q);
      ts[0] <= 32'(xa);
      tc[0] <= ONE_Q;
      s[0]  <= 34'(xa);
      c[0]  <= ONE_A;
    end
  end

  for (genvar t = 0; t < N_TERMS; t++) begin : g_term
    localparam int unsigned DS  = (2 * t + 2) * (2 * t + 3);
    localparam int unsigned DC  = (2 * t + 1) * (2 * t + 2);
    localparam logic [31:0] MS  = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] MC  = 32'((64'd1 << 32) / DC);
    localparam bit          SUB = (t % 2 == 0);

    logic               v1, v2;
    logic [1:0]         q1, q2;
    logic [31:0]        x21, x22;
    logic signed [33:0] s1, s2, c1, c2;
    logic [31:0]        ps1, pc1, ps2, pc2, qs2, qc2;
    logic [32:0]        rs, rc;
    logic [31:0]        ts_n, tc_n;

    always_ff @(posedge clk) begin
      if (rst) begin
        v1       <= 1'b0;
        v2       <= 1'b0;
        v[t+1]   <= 1'b0;
      end else if (en) begin
        v1       <= v[t];
        v2       <= v1;
        v[t+1]   <= v2;
      end
    end

    // term times x squared
    always_ff @(posedge clk) begin
      if (en) begin
        q1  <= q[t];
        x21 <= x2[t];
        s1  <= s[t];
        c1  <= c[t];
        ps1 <= 32'((64'(ts[t]) * 64'(x2[t])) >> FRAC_Q);
        pc1 <= 32'((64'(tc[t]) * 64'(x2[t])) >> FRAC_Q);
      end
    end

    // reciprocal estimate of the constant divide, low by at most one
    always_ff @(posedge clk) begin
      if (en) begin
        q2  <= q1;
        x22 <= x21;
        s2  <= s1;
        c2  <= c1;
        ps2 <= ps1;
        pc2 <= pc1;
        qs2 <= 32'((64'(ps1) * 64'(MS)) >> 32);
        qc2 <= 32'((64'(pc1) * 64'(MC)) >> 32);
      end
    end

    // correct the estimate and accumulate with alternating sign
    always_comb begin
      rs   = {1'b0, ps2} - 33'(33'(qs2) * 33'(DS));
      rc   = {1'b0, pc2} - 33'(33'(qc2) * 33'(DC));
      ts_n = (rs >= 33'(DS)) ? qs2 + 32'd1 : qs2;
      tc_n = (rc >= 33'(DC)) ? qc2 + 32'd1 : qc2;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q[t+1]  <= q2;
        x2[t+1] <= x22;
        ts[t+1] <= ts_n;
        tc[t+1] <= tc_n;
        if (SUB) begin
          s[t+1] <= s2 - $signed(34'(ts_n));
          c[t+1] <= c2 - $signed(34'(tc_n));
        end else begin
          s[t+1] <= s2 + $signed(34'(ts_n));
          c[t+1] <= c2 + $signed(34'(tc_n));
        end
      end
    end
  end

  // clamp to [0, 1] and map by quadrant
  logic signed [31:0] s_cl, c_cl;
  logic               vc;

  always_comb begin
    if (s[N_TERMS] < 0) begin
      s_cl = '0;
    end else if (s[N_TERMS] > ONE_A) begin
      s_cl = $signed(ONE_Q);
    end else begin
      s_cl = 32'(s[N_TERMS]);
    end
    if (c[N_TERMS] < 0) begin
      c_cl = '0;
    end else if (c[N_TERMS] > ONE_A) begin
      c_cl = $signed(ONE_Q);
    end else begin
      c_cl = 32'(c[N_TERMS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= v[N_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (q[N_TERMS])
        2'd0: begin
          sn <= s_cl;
          cs <= c_cl;
        end
        2'd1: begin
          sn <= c_cl;
          cs <= -s_cl;
        end
        2'd2: begin
          sn <= -s_cl;
          cs <= -c_cl;
        end
        default: begin
          sn <= -c_cl;
          cs <= s_cl;
        end
      endcase
    end
  end

  assign out_valid = vc;

endmodule

`default_nettype wire

### hdl/uvs_coord.sv
// ----------------------------------------------------------------------------
// uvs_coord
// Vertex coordinate products and rounding from Q60 to the output format.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_coord import uvs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [31:0]      s_st,
  input  logic signed [31:0]      c_st,
  input  logic signed [31:0]      s_se,
  input  logic signed [31:0]      c_se,
  output logic                    out_valid,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z
);

  localparam int SH = 2 * FRAC_Q - COORD_FRAC_BITS;

  // round magnitude half away from zero, clamp to one, reapply sign
  function automatic logic [POS_W-1:0] to_coord(input logic signed [63:0] v);
    logic        neg;
    logic [63:0] mag;
    neg = v[63];
    mag = neg ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (SH - 1))) >> SH;
    if (mag > (64'd1 << COORD_FRAC_BITS)) begin
      mag = 64'd1 << COORD_FRAC_BITS;
    end
    return neg ? POS_W'(-mag) : POS_W'(mag);
  endfunction

  logic               v1, v2;
  logic signed [63:0] px, py, pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // exact Q60 products
  always_ff @(posedge clk) begin
    if (en) begin
      px <= 64'(c_st) * 64'(c_se);
      py <= 64'(c_st) * 64'(s_se);
      pz <= 64'(s_st) <<< FRAC_Q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      pos_x <= $signed(to_coord(px));
      pos_y <= $signed(to_coord(py));
      pos_z <= $signed(to_coord(pz));
    end
  end

  assign out_valid = v2;

endmodule

`default_nettype wire

### hdl/uv_sphere_vertex_and_quad_gen.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_and_quad_gen
// Unit-sphere vertex and quad triangle indices for one grid position per word.
// ----------------------------------------------------------------------------
// pipeline: grid word accepted to vertex word valid through 21 divider stages,
//   27 sine/cosine stages and 2 coordinate stages
// throughput: one word per cycle; the whole pipeline holds while the output
//   word waits
// reset: synchronous, clears all valid bits and loads sector count 36, stack 18
`default_nettype none

module uv_sphere_vertex_and_quad_gen import uvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  cfg_reg_t           cfg_index,
  input  logic [COUNT_W-1:0] cfg_data,
  uvs_in_if.sink             grid,
  uvs_out_if.source          mesh
);

  // zero raised to one, cap at MAX_DIVISIONS - 1 (1023)
  function automatic count_t fix_count(input count_t v);
    count_t c;
    c = v;
    if (c == '0) begin
      c = COUNT_W'(1);
    end
    if (int'(c) > MAX_DIVISIONS - 1) begin
      c = COUNT_W'(MAX_DIVISIONS - 1);
    end
    return c;
  endfunction

  count_t sectors, stacks;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sectors <= COUNT_W'(SECTOR_RESET);
      stacks  <= COUNT_W'(STACK_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SECTOR_COUNT: sectors <= fix_count(cfg_data);
        REG_STACK_COUNT:  stacks  <= fix_count(cfg_data);
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  assign en         = !mesh.valid || mesh.ready;
  assign grid.ready = en;

  // phase division
  logic               div_valid;
  logic [PHASE_W-1:0] sec_quo, stk_quo;

  uvs_phase_div u_div (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (grid.valid),
    .stack_index  (grid.stack_index),
    .sector_index (grid.sector_index),
    .sectors      (sectors),
    .stacks       (stacks),
    .out_valid    (div_valid),
    .sec_quo      (sec_quo),
    .stk_quo      (stk_quo)
  );

  // stack angle is a quarter turn minus the stack index times the stack step
  logic [PHASE_W-1:0] stk_phase;
  assign stk_phase = PHASE_W'(32'h4000_0000 - stk_quo);

  logic               st_valid, se_valid;
  logic signed [31:0] s_st, c_st, s_se, c_se;

  uvs_sincos u_sc_stack (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .phase     (stk_phase),
    .out_valid (st_valid),
    .sn        (s_st),
    .cs        (c_st)
  );

  uvs_sincos u_sc_sector (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .phase     (sec_quo),
    .out_valid (se_valid),
    .sn        (s_se),
    .cs        (c_se)
  );

  logic co_valid;

  uvs_coord u_coord (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (st_valid && se_valid),
    .s_st      (s_st),
    .c_st      (c_st),
    .s_se      (s_se),
    .c_se      (c_se),
    .out_valid (co_valid),
    .pos_x     (mesh.pos_x),
    .pos_y     (mesh.pos_y),
    .pos_z     (mesh.pos_z)
  );

  // quad indices and flags
  side_t            side_in;
  logic [TRI_W-1:0] row_len;

  always_comb begin
    row_len           = TRI_W'(sectors) + TRI_W'(1);
    side_in.a         = TRI_W'(TRI_W'(grid.stack_index) * row_len)
                        + TRI_W'(grid.sector_index);
    side_in.b         = side_in.a + row_len;
    side_in.a1        = side_in.a + TRI_W'(1);
    side_in.b1        = side_in.b + TRI_W'(1);
    side_in.vertex_ok = (grid.stack_index <= stacks) && (grid.sector_index <= sectors);
    side_in.quad_ok   = (grid.stack_index < stacks) && (grid.sector_index < sectors);
  end

  // delay line matched to the math pipeline
  side_t side_q [PIPE_DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign mesh.valid     = co_valid;
  assign mesh.vertex_ok = side_q[PIPE_DEPTH-1].vertex_ok;
  assign mesh.quad_ok   = side_q[PIPE_DEPTH-1].quad_ok;
  assign mesh.tri0_a    = side_q[PIPE_DEPTH-1].a;
  assign mesh.tri0_b    = side_q[PIPE_DEPTH-1].b;
  assign mesh.tri0_c    = side_q[PIPE_DEPTH-1].a1;
  assign mesh.tri1_a    = side_q[PIPE_DEPTH-1].b;
  assign mesh.tri1_b    = side_q[PIPE_DEPTH-1].b1;
  assign mesh.tri1_c    = side_q[PIPE_DEPTH-1].a1;

endmodule

`default_nettype wire
